@@ src/lcd_pkg.sv @@
// Shared types and constants for the line command decoder.
// Used by lcd_line_tracker and line_command_decoder_top; depends on nothing else.
package lcd_pkg;

  // Longest line buffer the original firmware kept, including the terminator.
  localparam int LINE_BYTES = 64;
  // Width of the line length counter; at least four bits so that the exact
  // keyword lengths (nine and ten) can be compared.
  localparam int LEN_W = ($clog2(LINE_BYTES) < 4) ? 4 : $clog2(LINE_BYTES);

  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_OVERRUN = 1'b1;

  localparam logic TGT_DISPLAY = 1'b0;
  localparam logic TGT_RECOG   = 1'b1;

  localparam logic [7:0] CH_NUL     = 8'd0;
  localparam logic [7:0] CH_NEWLINE = 8'd10;

  typedef enum logic [3:0] {
    CMD_OFF         = 4'd0,
    CMD_ON          = 4'd1,
    CMD_ENROLL      = 4'd2,
    CMD_DETECT      = 4'd3,
    CMD_DELETE_ALL  = 4'd4,
    CMD_THRESH_UP   = 4'd5,
    CMD_THRESH_DOWN = 4'd6,
    CMD_GOTO_IDLE   = 4'd7,
    CMD_DELETE      = 4'd8
  } lcd_cmd_t;

  typedef struct packed {
    logic               hit;
    logic               target;
    lcd_cmd_t           command;
    logic signed [31:0] entry_id;
  } lcd_result_t;

  // Characters of the raise-threshold line, indexed by position in the line.
  function automatic logic [7:0] kw_up_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0: c = "t";
      4'd1: c = "h";
      4'd2: c = "r";
      4'd3: c = "e";
      4'd4: c = "s";
      4'd5: c = "h";
      4'd6: c = "_";
      4'd7: c = "u";
      4'd8: c = "p";
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  // Characters of the lower-threshold line.
  function automatic logic [7:0] kw_dwn_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0: c = "t";
      4'd1: c = "h";
      4'd2: c = "r";
      4'd3: c = "e";
      4'd4: c = "s";
      4'd5: c = "h";
      4'd6: c = "_";
      4'd7: c = "d";
      4'd8: c = "w";
      4'd9: c = "n";
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  // Characters of the "del" prefix.
  function automatic logic [7:0] kw_del_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0: c = "d";
      2'd1: c = "e";
      2'd2: c = "l";
      default: c = 8'd0;
    endcase
    return c;
  endfunction

endpackage

@@ src/lcd_line_tracker.sv @@
// Per-line running match state and end-of-line command decode.
// Depends on lcd_pkg; instantiated by line_command_decoder_top.
module lcd_line_tracker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  logic               kind,
  input  logic [7:0]         rx_byte,
  output lcd_pkg::lcd_result_t result
);

  typedef enum logic [1:0] {
    PH_BLANK  = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  localparam logic [5:0]  HIT_OFF = 6'b000001;
  localparam logic [5:0]  HIT_ONL = 6'b000010;
  localparam logic [5:0]  HIT_ENR = 6'b000100;
  localparam logic [5:0]  HIT_REC = 6'b001000;
  localparam logic [5:0]  HIT_REM = 6'b010000;
  localparam logic [5:0]  HIT_GOT = 6'b100000;
  localparam logic [31:0] MAG_MAX = 32'h8000_0000;
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [lcd_pkg::LEN_W-1:0] LEN_SAT = lcd_pkg::LEN_W'(lcd_pkg::LINE_BYTES - 1);

  logic [lcd_pkg::LEN_W-1:0] len_r, len_nxt;
  logic                      nul_r, nul_nxt;
  logic [15:0]               recent_r, recent_nxt;
  logic [5:0]                hits_r, hits_nxt;
  logic [1:0]                exact_r, exact_nxt;
  logic                      del_ok_r, del_ok_nxt;
  phase_t                    phase_r, phase_nxt;
  logic                      neg_r, neg_nxt;
  logic [31:0]               value_r, value_nxt;

  logic [23:0] window;
  logic        is_nul;
  logic        is_digit;
  logic        is_blank;
  logic [35:0] value_ext;

  assign is_nul   = (rx_byte == lcd_pkg::CH_NUL);
  assign window   = {recent_r, rx_byte};
  assign is_digit = (rx_byte >= "0") && (rx_byte <= "9");
  assign is_blank = ((rx_byte >= 8'd9) && (rx_byte <= 8'd13)) || (rx_byte == " ");
  // value * 10 + digit as two shifts and adds.
  assign value_ext = {1'b0, value_r, 3'b000} + {3'b000, value_r, 1'b0}
                   + {32'd0, rx_byte[3:0]};

  always_comb begin
    len_nxt    = len_r;
    nul_nxt    = nul_r;
    recent_nxt = recent_r;
    hits_nxt   = hits_r;
    exact_nxt  = exact_r;
    del_ok_nxt = del_ok_r;
    phase_nxt  = phase_r;
    neg_nxt    = neg_r;
    value_nxt  = value_r;

    if (step_en) begin
      if ((kind == lcd_pkg::KIND_OVERRUN) || (rx_byte == lcd_pkg::CH_NEWLINE)) begin
        len_nxt    = '0;
        nul_nxt    = 1'b0;
        recent_nxt = '0;
        hits_nxt   = '0;
        exact_nxt  = 2'b11;
        del_ok_nxt = 1'b1;
        phase_nxt  = PH_BLANK;
        neg_nxt    = 1'b0;
        value_nxt  = '0;
      end else begin
        if (len_r < LEN_SAT) begin
          len_nxt = len_r + 1'b1;
        end
        if (!nul_r) begin
          // Exact-line candidates: a NUL counts only right after the keyword.
          if (is_nul) begin
            if (len_r != lcd_pkg::LEN_W'(9))  exact_nxt[0] = 1'b0;
            if (len_r != lcd_pkg::LEN_W'(10)) exact_nxt[1] = 1'b0;
          end else begin
            if (!((len_r < lcd_pkg::LEN_W'(9)) &&
                  (rx_byte == lcd_pkg::kw_up_char(len_r[3:0])))) begin
              exact_nxt[0] = 1'b0;
            end
            if (!((len_r < lcd_pkg::LEN_W'(10)) &&
                  (rx_byte == lcd_pkg::kw_dwn_char(len_r[3:0])))) begin
              exact_nxt[1] = 1'b0;
            end
          end
          if ((len_r < lcd_pkg::LEN_W'(3)) &&
              (is_nul || (rx_byte != lcd_pkg::kw_del_char(len_r[1:0])))) begin
            del_ok_nxt = 1'b0;
          end

          if (is_nul) begin
            nul_nxt = 1'b1;
          end else begin
            if (window == {"o", "f", "f"}) hits_nxt = hits_nxt | HIT_OFF;
            if (window == {"o", "n", "L"}) hits_nxt = hits_nxt | HIT_ONL;
            if (window == {"e", "n", "r"}) hits_nxt = hits_nxt | HIT_ENR;
            if (window == {"r", "e", "c"}) hits_nxt = hits_nxt | HIT_REC;
            if (window == {"r", "e", "m"}) hits_nxt = hits_nxt | HIT_REM;
            if (window == {"g", "o", "t"}) hits_nxt = hits_nxt | HIT_GOT;
            recent_nxt = window[15:0];

            // Id digits after the "del" prefix position, read like atoi.
            if ((len_r >= lcd_pkg::LEN_W'(3)) && (phase_r != PH_DONE)) begin
              priority if ((phase_r == PH_BLANK) && is_blank) begin
                phase_nxt = PH_BLANK;
              end else if ((phase_r == PH_BLANK) && ((rx_byte == "+") || (rx_byte == "-"))) begin
                neg_nxt   = (rx_byte == "-");
                phase_nxt = PH_DIGITS;
              end else if (is_digit) begin
                value_nxt = (value_ext > {4'd0, MAG_MAX}) ? MAG_MAX : value_ext[31:0];
                phase_nxt = PH_DIGITS;
              end else begin
                phase_nxt = PH_DONE;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= '0;
      nul_r    <= 1'b0;
      recent_r <= '0;
      hits_r   <= '0;
      exact_r  <= 2'b11;
      del_ok_r <= 1'b1;
      phase_r  <= PH_BLANK;
      neg_r    <= 1'b0;
      value_r  <= '0;
    end else begin
      len_r    <= len_nxt;
      nul_r    <= nul_nxt;
      recent_r <= recent_nxt;
      hits_r   <= hits_nxt;
      exact_r  <= exact_nxt;
      del_ok_r <= del_ok_nxt;
      phase_r  <= phase_nxt;
      neg_r    <= neg_nxt;
      value_r  <= value_nxt;
    end
  end

  // End-of-line decode from the running state, in fixed priority.
  always_comb begin
    result.hit      = 1'b1;
    result.target   = lcd_pkg::TGT_RECOG;
    result.command  = lcd_pkg::CMD_OFF;
    result.entry_id = -32'sd1;
    priority if ((len_r == '0) || (len_r >= LEN_SAT)) begin
      result.hit = 1'b0;
    end else if ((hits_r & HIT_OFF) != '0) begin
      result.target  = lcd_pkg::TGT_DISPLAY;
      result.command = lcd_pkg::CMD_OFF;
    end else if ((hits_r & HIT_ONL) != '0) begin
      result.target  = lcd_pkg::TGT_DISPLAY;
      result.command = lcd_pkg::CMD_ON;
    end else if ((hits_r & HIT_ENR) != '0) begin
      result.command = lcd_pkg::CMD_ENROLL;
    end else if ((hits_r & HIT_REC) != '0) begin
      result.command = lcd_pkg::CMD_DETECT;
    end else if ((hits_r & HIT_REM) != '0) begin
      result.command = lcd_pkg::CMD_DELETE_ALL;
    end else if (exact_r[0] && (nul_r || (len_r == lcd_pkg::LEN_W'(9)))) begin
      result.command = lcd_pkg::CMD_THRESH_UP;
    end else if (exact_r[1] && (nul_r || (len_r == lcd_pkg::LEN_W'(10)))) begin
      result.command = lcd_pkg::CMD_THRESH_DOWN;
    end else if ((hits_r & HIT_GOT) != '0) begin
      result.command = lcd_pkg::CMD_GOTO_IDLE;
    end else if (del_ok_r && (len_r >= lcd_pkg::LEN_W'(3))) begin
      result.command = lcd_pkg::CMD_DELETE;
      if (neg_r) begin
        result.entry_id = $signed(32'd0 - value_r);
      end else begin
        result.entry_id = $signed((value_r > POS_MAX) ? POS_MAX : value_r);
      end
    end else begin
      result.hit = 1'b0;
    end
    if ((kind != lcd_pkg::KIND_BYTE) || (rx_byte != lcd_pkg::CH_NEWLINE)) begin
      result.hit = 1'b0;
    end
  end

endmodule

@@ src/line_command_decoder_top.sv @@
// Top level of the line command decoder: input register, line tracker and result register.
// Depends on lcd_pkg and lcd_line_tracker.
//
// The decoder takes one received serial byte (or a receiver overrun event) per request
// and builds up lines ended by a newline. While bytes arrive it keeps running keyword
// flags, so at the newline it can issue at most one command: the substrings off, onL,
// enr, rec and rem, then the two exact threshold lines ("thresh_" followed by up or
// dwn), then the substring got, then a line starting with del followed by a decimal id
// that saturates at 32 bits. Empty, unknown and overlong lines (63 bytes or more)
// produce no result, a NUL stops matching for the rest of its line, and an overrun
// drops the line in progress. A request is registered on acceptance and then processed
// from the input register, so one byte can be accepted every clock while in_stall is
// low; a command is decoded from the input register and loaded into the output register,
// where the receiver can take it. The output register lets the next request in while a
// command waits; input stall rises only when a newline that decodes to a command is
// waiting behind a command the receiver has not yet taken.
module line_command_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_target,
  output logic [3:0]  out_command,
  output logic [31:0] out_entry_id
);

  // Input register.
  logic       req_valid_r;
  logic       req_kind_r;
  logic [7:0] req_byte_r;

  // Result register.
  logic                 res_valid_r;
  lcd_pkg::lcd_result_t res_r;

  lcd_pkg::lcd_result_t decode;
  logic                 blocked;
  logic                 step_en;
  logic                 in_take;

  // A pending command can only move on once the output register is free.
  assign blocked  = req_valid_r && decode.hit && res_valid_r && out_stall;
  assign step_en  = req_valid_r && !blocked;
  assign in_stall = blocked;
  assign in_take  = in_valid && !in_stall;

  lcd_line_tracker u_tracker (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .kind    (req_kind_r),
    .rx_byte (req_byte_r),
    .result  (decode)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      if (!blocked) begin
        req_valid_r <= in_take;
      end
      if (step_en && decode.hit) begin
        res_valid_r <= 1'b1;
      end else if (res_valid_r && !out_stall) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_kind_r <= in_kind;
      req_byte_r <= in_rx_byte;
    end
    if (step_en && decode.hit) begin
      res_r <= decode;
    end
  end

  assign out_valid    = res_valid_r;
  assign out_target   = res_r.target;
  assign out_command  = res_r.command;
  assign out_entry_id = res_r.entry_id;

endmodule
